/* design/rld_pkg.sv */
// ----------------------------------------------------------------------------
// rld_pkg: shared types and constants for the run list difference block
// Transaction payloads, request codes, table sizing and the control/status
// structs passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package rld_pkg;

  localparam int MaxRuns   = 32;
  localparam int CoordW    = 16;
  localparam int FieldW    = 16;
  localparam int CntW      = $clog2(MaxRuns + 1);
  localparam int AddrW     = (MaxRuns > 1) ? $clog2(MaxRuns) : 1;

  localparam logic [1:0] ReqClear    = 2'd0;
  localparam logic [1:0] ReqLoad     = 2'd1;
  localparam logic [1:0] ReqMinuend  = 2'd2;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [FieldW-1:0] run_start;
    logic signed [FieldW-1:0] run_end;
  } in_item_t;

  typedef struct packed {
    logic signed [FieldW-1:0] piece_start;
    logic signed [FieldW-1:0] piece_end;
    logic                     piece_last;
    logic                     overflow;
  } out_item_t;

  // One step of the table walk for a minuend run.
  typedef enum logic [2:0] {
    ActAdvance,   // entry lies left of cursor: move on
    ActSkip,      // entry covers cursor: jump cursor past it
    ActCut,       // emit piece before entry, continue past it
    ActCutEnd,    // emit piece before entry, entry covers the rest
    ActCovered,   // rest of run is covered, nothing left
    ActTail       // emit the remainder of the run
  } act_e;

  typedef struct packed {
    logic capture;        // latch incoming run
    logic clear;          // empty table
    logic rd_from_count;  // read the last stored entry
    logic load_commit;    // merge or append loaded run
    logic min_step;       // apply one walk step
  } ctl_cmd_t;

  typedef struct packed {
    act_e act;
    logic out_free;
  } dp_stat_t;

endpackage

/* design/run_list_difference.sv */
// ----------------------------------------------------------------------------
// run_list_difference: scanline run list subtraction
// Loads a table of subtrahend runs and cuts minuend runs against it.
// ----------------------------------------------------------------------------
// A clear transaction is carried out as it is accepted; a load transaction
// reads the last stored run, then merges or appends in LoadS. A minuend
// transaction latches the run, then walks the table in WalkS: one step for
// each subtrahend entry the walk pointer passes or cuts on, plus one final
// step; each step that produces a piece waits while the single result
// register is still stalled. The table is a 32 entry memory with one read
// and one write port; the walk advances one entry per cycle unless a piece
// waits. Only entries below the stored count are used; no clear is needed.
module run_list_difference (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rld_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rld_pkg::out_item_t  out_item_o
);

  rld_pkg::ctl_cmd_t cmd;
  rld_pkg::dp_stat_t stat;

  rld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (in_item_i.req_type),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  rld_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clear, cmd.load_commit, cmd.min_step}))
    else $error("conflicting datapath commands");

  a_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.min_step || cmd.load_commit) |-> in_stall_o)
    else $error("datapath busy while input open");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.min_step && out_valid_o && out_stall_i) |->
      !(stat.act == rld_pkg::ActCut || stat.act == rld_pkg::ActCutEnd ||
        stat.act == rld_pkg::ActTail))
    else $error("piece overwrote a stalled result");

  a_piece_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.piece_start <= out_item_o.piece_end))
    else $error("piece with start beyond end");

endmodule

/* design/rld_datapath.sv */
// ----------------------------------------------------------------------------
// rld_datapath: run table, walk cursor and result register
// Holds the subtrahend table memory, the count, walk pointer and overflow
// flag, decides each walk step and registers the surviving pieces.
// ----------------------------------------------------------------------------
module rld_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rld_pkg::ctl_cmd_t   cmd_i,
  output rld_pkg::dp_stat_t   stat_o,
  input  rld_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rld_pkg::out_item_t  out_item_o
);

  localparam int W = rld_pkg::CoordW;

  logic [2*W-1:0]              mem_q [rld_pkg::MaxRuns];
  logic [2*W-1:0]              rd_q;
  logic [rld_pkg::AddrW-1:0]   rd_addr;
  logic                        wr_en;
  logic [rld_pkg::AddrW-1:0]   wr_addr;
  logic [2*W-1:0]              wr_data;

  logic [rld_pkg::CntW-1:0]    cnt_q, cnt_d, cnt_m1;
  logic [rld_pkg::CntW-1:0]    ptr_q, ptr_d;
  logic                        ovf_q, ovf_d;
  logic signed [W-1:0]         s_q, e_q, cur_q, cur_d;
  logic signed [W-1:0]         in_s, in_e;

  logic signed [W-1:0]         bs, be, be_p1, bs_m1;
  logic signed [W:0]           be_x, le_p1, s_x;
  logic                        merge;
  rld_pkg::act_e               act;
  logic                        emit;
  logic                        out_valid_q;
  rld_pkg::out_item_t          out_q, out_d;
  logic                        out_free;

  // Order the incoming endpoints.
  always_comb begin
    if (in_item_i.run_start > in_item_i.run_end) begin
      in_s = W'(in_item_i.run_end);
      in_e = W'(in_item_i.run_start);
    end else begin
      in_s = W'(in_item_i.run_start);
      in_e = W'(in_item_i.run_end);
    end
  end

  assign bs    = rd_q[2*W-1:W];
  assign be    = rd_q[W-1:0];
  assign be_p1 = be + W'(1);
  assign bs_m1 = bs - W'(1);
  assign cnt_m1 = cnt_q - rld_pkg::CntW'(1);

  // Load: merge when the run starts at or before last end + 1.
  assign be_x  = {be[W-1], be};
  assign le_p1 = be_x + (W+1)'(1);
  assign s_x   = {s_q[W-1], s_q};
  assign merge = (cnt_q != '0) && (s_x <= le_p1);

  // Walk step decision.
  always_comb begin
    if (ptr_q >= cnt_q) begin
      act = rld_pkg::ActTail;
    end else if (be < cur_q) begin
      act = rld_pkg::ActAdvance;
    end else if (bs <= cur_q) begin
      act = (be >= e_q) ? rld_pkg::ActCovered : rld_pkg::ActSkip;
    end else if (bs <= e_q) begin
      act = (be >= e_q) ? rld_pkg::ActCutEnd : rld_pkg::ActCut;
    end else begin
      act = rld_pkg::ActTail;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign stat_o.act = act;
  assign stat_o.out_free = out_free;

  always_comb begin
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    ovf_d   = ovf_q;
    cur_d   = cur_q;
    wr_en   = 1'b0;
    wr_addr = cnt_m1[rld_pkg::AddrW-1:0];
    wr_data = {bs, e_q};
    emit    = 1'b0;
    out_d   = out_q;
    if (cmd_i.clear) begin
      cnt_d = '0;
      ptr_d = '0;
      ovf_d = 1'b0;
    end
    if (cmd_i.capture) begin
      cur_d = in_s;
    end
    if (cmd_i.load_commit) begin
      if (merge) begin
        wr_en = (e_q > be);
      end else if (cnt_q < rld_pkg::CntW'(rld_pkg::MaxRuns)) begin
        wr_en   = 1'b1;
        wr_addr = cnt_q[rld_pkg::AddrW-1:0];
        wr_data = {s_q, e_q};
        cnt_d   = cnt_q + rld_pkg::CntW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.min_step) begin
      out_d.piece_start = cur_q;
      out_d.piece_end   = bs_m1;
      out_d.piece_last  = 1'b1;
      out_d.overflow    = ovf_q;
      case (act)
        rld_pkg::ActAdvance: begin
          ptr_d = ptr_q + rld_pkg::CntW'(1);
        end
        rld_pkg::ActSkip: begin
          cur_d = be_p1;
          ptr_d = ptr_q + rld_pkg::CntW'(1);
        end
        rld_pkg::ActCut: begin
          emit             = 1'b1;
          out_d.piece_last = 1'b0;
          cur_d            = be_p1;
          ptr_d            = ptr_q + rld_pkg::CntW'(1);
        end
        rld_pkg::ActCutEnd: begin
          emit = 1'b1;
        end
        rld_pkg::ActTail: begin
          emit            = 1'b1;
          out_d.piece_end = e_q;
        end
        default: begin
        end
      endcase
    end
  end

  // Walk reads the next pointer; a load reads the last stored entry.
  assign rd_addr = cmd_i.rd_from_count ? cnt_m1[rld_pkg::AddrW-1:0]
                                       : ptr_d[rld_pkg::AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ptr_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ptr_q <= ptr_d;
      ovf_q <= ovf_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      s_q <= in_s;
      e_q <= in_e;
    end
    cur_q <= cur_d;
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* design/rld_ctrl.sv */
// ----------------------------------------------------------------------------
// rld_ctrl: request sequencer
// Accepts one request at a time and carries out a clear, or steps the datapath
// through a load update or a minuend walk, holding emitting steps on a stall.
// ----------------------------------------------------------------------------
module rld_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         req_type_i,
  output logic               in_stall_o,
  output rld_pkg::ctl_cmd_t  cmd_o,
  input  rld_pkg::dp_stat_t  stat_i
);

  typedef enum logic [1:0] {
    IdleS,
    LoadS,
    WalkS
  } state_e;

  state_e state_q, state_d;
  logic   accept;
  logic   emits;
  logic   done;

  assign accept = in_valid_i && (state_q == IdleS);
  assign emits  = (stat_i.act == rld_pkg::ActCut) || (stat_i.act == rld_pkg::ActCutEnd) ||
                  (stat_i.act == rld_pkg::ActTail);
  assign done   = (stat_i.act == rld_pkg::ActCutEnd) ||
                  (stat_i.act == rld_pkg::ActCovered) || (stat_i.act == rld_pkg::ActTail);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      IdleS: begin
        cmd_o.capture       = accept;
        cmd_o.clear         = accept && (req_type_i == rld_pkg::ReqClear);
        cmd_o.rd_from_count = (req_type_i == rld_pkg::ReqLoad);
        if (accept && (req_type_i == rld_pkg::ReqLoad)) begin
          state_d = LoadS;
        end else if (accept && (req_type_i == rld_pkg::ReqMinuend)) begin
          state_d = WalkS;
        end
      end
      LoadS: begin
        cmd_o.load_commit = 1'b1;
        state_d           = IdleS;
      end
      WalkS: begin
        // hold while a piece would overwrite a result not yet taken
        if (!emits || stat_i.out_free) begin
          cmd_o.min_step = 1'b1;
          if (done) begin
            state_d = IdleS;
          end
        end
      end
      default: begin
        state_d = IdleS;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IdleS;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != IdleS);

endmodule
